/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL modules (included by the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hw/rtl/thwb_pkg.sv */
// Types, codes and defaults for the timestamped history window buffer.
package thwb_pkg;
    localparam int DEPTH_DEF        = 32;
    localparam int PAYLOAD_BITS_DEF = 64;
    localparam int STAMP_W          = 63;
    localparam int WORD_W           = 64;
    localparam int COUNT_W          = 6;

    localparam logic [1:0] FUNC_PUSH    = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
    localparam logic [1:0] FUNC_SEGMENT = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] end_stamp;
        logic [WORD_W-1:0]  payload;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [STAMP_W-1:0] out_stamp;
        logic [WORD_W-1:0]  out_payload;
        logic               last;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] oldest_stamp;
        logic [STAMP_W-1:0] latest_stamp;
        logic [STAMP_W-1:0] span_ns;
        logic [STAMP_W-1:0] period_ns;
        logic               overflow;
    } t_out_item;
endpackage

/* hw/rtl/timestamped_history_window_buffer.sv */
// Top level of the timestamped history window buffer.
// Usage:
//   Input channel i_in_valid/o_in_ready carries one transaction: push, lookup or
//   segment. Output channel o_out_valid/i_out_ready returns result transactions;
//   the final one of each input has last set. The user must write the window
//   length via i_cfg_we/i_cfg_data only while the block is idle (not enforced).
//   Entries sit in two RAMs with one read port; a sequencer walks them through
//   that port, a read state then a check state per entry visited.
//   Push: S_PUSH, S_PRD/S_PCHK per entry checked to prune, S_DONE; one result.
//   Lookup: S_SRD/S_SCHK per entry visited, then S_DONE; one result.
//   Segment: as lookup; one result per matching entry, or one if none match.
//   One transaction is in work at a time; o_in_ready is low until its final
//   result sits in the output register.
//   A stalled receiver holds the output register; the sequencer waits for it.
//   Reset empties the history, clears the period and the window, and drops any
//   pending result. Stored entries need no clearing.
module timestamped_history_window_buffer #(
    parameter int DEPTH        = thwb_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = thwb_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  thwb_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output thwb_pkg::t_out_item               o_out,
    input  logic                              i_cfg_we,
    input  logic [thwb_pkg::STAMP_W-1:0]      i_cfg_data
);
`include "assert_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = thwb_pkg::STAMP_W;
    localparam int WW = thwb_pkg::WORD_W;

    typedef enum logic [2:0] {
        S_IDLE, S_PUSH, S_PRD, S_PCHK, S_SRD, S_SCHK, S_DONE
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_head;
    logic [AW-1:0]         r_i;
    logic [SW-1:0]         r_period;
    logic [SW-1:0]         r_window;
    logic [SW-1:0]         r_oldest;
    logic [SW-1:0]         r_newest;
    logic [1:0]            r_func;
    logic [SW-1:0]         r_q;
    logic [SW-1:0]         r_end;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic                  r_hit;
    logic [SW-1:0]         r_hs;
    logic [WW-1:0]         r_hp;
    logic                  r_ovf;
    logic [SW-1:0]         r_cut;
    logic                  r_pen;
    logic                  r_out_valid;
    thwb_pkg::t_out_item   r_out;

    logic                  w_clear;
    logic                  w_ovf;
    logic [CW-1:0]         w_base;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;
    logic [SW-1:0]         w_rstamp;
    logic [PAYLOAD_BITS-1:0] w_rpay;
    logic                  w_free;
    logic                  w_lastidx;
    thwb_pkg::t_out_item   w_out_base;
    thwb_pkg::t_out_item   w_out_next;
    logic                  w_seg_emit;
    logic                  w_emit;
    logic                  w_in_take;
    logic                  w_push_done;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign w_clear   = (r_count != '0) && (r_q < r_newest);
    assign w_ovf     = !w_clear && (r_count == CW'(DEPTH));
    assign w_base    = w_clear ? '0 : r_count;
    assign w_waddr   = w_ovf ? r_head : f_wrap(r_head, w_base);
    assign w_raddr   = (r_state == S_PRD || r_state == S_PCHK) ? r_head
                                                               : f_wrap(r_head, CW'(r_i));
    assign w_free    = !r_out_valid || i_out_ready;
    assign w_lastidx = ((CW'(r_i) + CW'(1)) == r_count);
    assign w_in_take = i_in_valid && (r_state == S_IDLE);
    assign w_seg_emit = (r_state == S_SCHK) && (r_func != thwb_pkg::FUNC_LOOKUP) && r_hit
                        && (w_rstamp >= r_q) && (w_rstamp <= r_end);
    assign w_emit    = w_free && ((r_state == S_DONE) || w_seg_emit);
    assign w_push_done = (r_state == S_DONE) && r_hit && (r_func == thwb_pkg::FUNC_PUSH);

    thwb_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_PUSH),
        .i_waddr (w_waddr),
        .i_wdata (r_q),
        .i_raddr (w_raddr),
        .o_rdata (w_rstamp)
    );

    thwb_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(DEPTH)) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_PUSH),
        .i_waddr (w_waddr),
        .i_wdata (r_pay),
        .i_raddr (w_raddr),
        .o_rdata (w_rpay)
    );

    always_comb begin
        w_out_base              = '0;
        w_out_base.count        = thwb_pkg::COUNT_W'(r_count);
        w_out_base.period_ns    = r_period;
        if (r_count != '0) begin
            w_out_base.oldest_stamp = r_oldest;
            w_out_base.latest_stamp = r_newest;
        end
        if (r_count >= CW'(2) && r_newest > r_oldest) begin
            w_out_base.span_ns = r_newest - r_oldest;
        end
    end

    always_comb begin
        w_out_next = w_out_base;
        if (r_state == S_DONE) begin
            w_out_next.found       = r_hit;
            w_out_next.out_stamp   = r_hit ? r_hs : '0;
            w_out_next.out_payload = r_hit ? r_hp : '0;
            w_out_next.last        = 1'b1;
            w_out_next.overflow    = r_ovf;
        end else begin
            w_out_next.found       = 1'b1;
            w_out_next.out_stamp   = r_hs;
            w_out_next.out_payload = r_hp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_period    <= '0;
            r_window    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_out       <= w_out_next;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_func <= i_in.func;
                        r_q    <= i_in.stamp;
                        r_end  <= i_in.end_stamp;
                        r_pay  <= i_in.payload[PAYLOAD_BITS-1:0];
                        r_hit  <= 1'b0;
                        r_hs   <= '0;
                        r_hp   <= '0;
                        r_ovf  <= 1'b0;
                        r_i    <= '0;
                        unique case (i_in.func)
                            thwb_pkg::FUNC_PUSH:
                                r_state <= (i_in.stamp == '0) ? S_DONE : S_PUSH;
                            thwb_pkg::FUNC_LOOKUP:
                                r_state <= (r_count != '0 && i_in.stamp != '0
                                            && i_in.stamp >= r_oldest) ? S_SRD : S_DONE;
                            thwb_pkg::FUNC_SEGMENT:
                                r_state <= (r_count != '0
                                            && i_in.end_stamp >= i_in.stamp) ? S_SRD : S_DONE;
                            default:
                                r_state <= S_DONE;
                        endcase
                    end
                end
                S_PUSH: begin
                    r_newest <= r_q;
                    if (w_base == '0) begin
                        r_oldest <= r_q;
                    end
                    if (w_clear) begin
                        r_period <= '0;
                    end else if (r_count != '0) begin
                        r_period <= r_q - r_newest;
                    end
                    if (w_ovf) begin
                        r_head <= f_wrap(r_head, CW'(1));
                    end else begin
                        r_count <= w_base + CW'(1);
                    end
                    r_ovf   <= w_ovf;
                    r_hit   <= 1'b1;
                    r_hs    <= r_q;
                    r_hp    <= WW'(r_pay);
                    r_cut   <= r_q - r_window;
                    r_pen   <= (r_window != '0) && (r_q > r_window);
                    r_state <= S_PRD;
                end
                S_PRD: begin
                    r_state <= S_PCHK;
                end
                S_PCHK: begin
                    r_oldest <= w_rstamp;
                    if (r_pen && r_count > CW'(1) && w_rstamp < r_cut) begin
                        r_head  <= f_wrap(r_head, CW'(1));
                        r_count <= r_count - CW'(1);
                        r_state <= S_PRD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SRD: begin
                    r_state <= S_SCHK;
                end
                S_SCHK: begin
                    if (r_func == thwb_pkg::FUNC_LOOKUP) begin
                        if (w_rstamp <= r_q) begin
                            r_hit   <= 1'b1;
                            r_hs    <= w_rstamp;
                            r_hp    <= WW'(w_rpay);
                            r_i     <= r_i + AW'(1);
                            r_state <= w_lastidx ? S_DONE : S_SRD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else if (w_rstamp < r_q) begin
                        r_i     <= r_i + AW'(1);
                        r_state <= w_lastidx ? S_DONE : S_SRD;
                    end else if (w_rstamp > r_end) begin
                        r_state <= S_DONE;
                    end else if (!r_hit || w_free) begin
                        r_hit   <= 1'b1;
                        r_hs    <= w_rstamp;
                        r_hp    <= WW'(w_rpay);
                        r_i     <= r_i + AW'(1);
                        r_state <= w_lastidx ? S_DONE : S_SRD;
                    end
                end
                S_DONE: begin
                    if (w_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count above depth")
    `ASSERT_IMPLY(a_push_nonempty, i_clk, i_rst_n, w_push_done, r_count != '0, "push left ring empty")
    `ASSERT_IMPLY(a_order, i_clk, i_rst_n, r_count != '0 && r_state == S_IDLE, r_oldest <= r_newest, "oldest after newest")
    `ASSERT_IMPLY(a_busy_in, i_clk, i_rst_n, r_state != S_IDLE, !o_in_ready, "ready while busy")
endmodule

/* hw/rtl/thwb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module thwb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
